// ===== hdl/mjpid_pkg.sv =====
// Shared constants, types and a helper function of the multi-joint PID regulator.
`default_nettype none

package mjpid_pkg;

	// Joint and field geometry.
	localparam int JOINT_COUNT = 5;
	localparam int GAIN_BITS   = 12;
	localparam int GAIN_SLOTS  = 5;
	localparam int GAINS_W     = 60;
	localparam int JIDX_W      = 3;
	localparam int ERR_W       = 16;
	localparam int TICK_W      = 16;
	localparam int WIN_W       = 15;
	localparam int SLOPE_W     = 16;
	localparam int SUM_W       = 32;
	localparam int TORQUE_W    = 32;

	// Datapath widths.
	localparam int DIFF_W  = ERR_W + 1;
	localparam int MUL_A_W = SUM_W + 1;
	localparam int MUL_B_W = DIFF_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int PT_W    = GAIN_BITS + ERR_W + 1;
	localparam int DIVD_W  = GAIN_BITS + DIFF_W + 1;
	localparam int ET_W    = ERR_W + TICK_W + 1;
	localparam int IT_W    = GAIN_BITS + SUM_W + 1;
	localparam int TOT_W   = IT_W + 2;

	// State memory: previous error in the low bits, integral sum above it.
	localparam int RAM_W  = ERR_W + SUM_W;
	localparam int RAM_AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

	// Register reset values.
	localparam logic [WIN_W-1:0]   WINDOW_RESET = 15'd410;
	localparam logic [SLOPE_W-1:0] SLOPE_RESET  = 16'd4096;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = 3'd4;

	// Divider status seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Picks one joint's 12-bit gain out of a packed register; joints without a slot get zero.
	function automatic logic [GAIN_BITS-1:0] gain_of(input logic [GAINS_W-1:0] pg,
			input logic [JIDX_W-1:0] joint);
		logic [GAIN_BITS-1:0] g;
		g = '0;
		for (int i = 0; i < GAIN_SLOTS; i++) begin
			if (joint == JIDX_W'(i)) begin
				g = pg[i*GAIN_BITS +: GAIN_BITS];
			end
		end
		return g;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mjpid_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mjpid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/mjpid_div.sv =====
// Bit-serial signed-by-unsigned divider that truncates toward zero.
`default_nettype none

module mjpid_div (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic signed [mjpid_pkg::DIVD_W-1:0]   dividend,
	input  wire logic        [mjpid_pkg::TICK_W-1:0]   divisor,
	output logic signed      [mjpid_pkg::DIVD_W-1:0]   quotient,
	output mjpid_pkg::div_stat_t                       stat
);
	import mjpid_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] num_q;
	logic [TICK_W-1:0] rem_q;
	logic [TICK_W-1:0] den_q;
	logic [TICK_W:0]   trial;
	logic              fits;
	logic [DIVD_W-1:0] mag;

	// One restoring step: shift in the next dividend bit and try the subtract.
	always_comb begin
		trial = {rem_q, num_q[DIVD_W-1]};
		fits  = (trial >= {1'b0, den_q});
		mag   = dividend[DIVD_W-1] ? (-dividend) : dividend;
	end

	// Control: busy for one cycle per quotient bit, done held until the next start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits as it empties.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= mag;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[DIVD_W-1];
		end else if (busy_q) begin
			num_q <= {num_q[DIVD_W-2:0], fits};
			if (fits) begin
				rem_q <= TICK_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[TICK_W-1:0];
			end
		end
	end

	assign quotient  = neg_q ? $signed(-num_q) : $signed(num_q);
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ===== hdl/multi_joint_pid_conditional_integral_top.sv =====
// Top level of the multi-joint PID regulator with conditional integration.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser: joint_index; tdata: error, ticks
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: torque; tuser: saturated, integrating
//  cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One item at a time: the time from input transfer to result is set by the 30-step
// serial divider for the derivative term; the shared multiplier runs beside it.
// An out-of-range joint index goes straight to the result state with a zero result in
// the cycle after its transfer, and from there into the output register.
// Reset clears the gains and per-joint valid bits and presets window and slope; there is
// no clearing pass. A result waits in the output register while the next item is taken.
`default_nettype none

module multi_joint_pid_conditional_integral_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	input  wire logic [31:0]                            s_axis_tdata,  // joint_error, elapsed_ticks
	input  wire logic [7:0]                             s_axis_tuser,  // joint_index, zero fill
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	output logic [31:0]                                 m_axis_tdata,  // drive_torque
	output logic [7:0]                                  m_axis_tuser,  // torque_saturated,
	                                                                   // integrating, zero fill
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [mjpid_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [mjpid_pkg::GAINS_W-1:0]          cfg_data
);
	import mjpid_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_READ = 11'b000_0000_0010,
		S_MP   = 11'b000_0000_0100,
		S_MD   = 11'b000_0000_1000,
		S_MS   = 11'b000_0001_0000,
		S_ME   = 11'b000_0010_0000,
		S_SUM  = 11'b000_0100_0000,
		S_MI   = 11'b000_1000_0000,
		S_WI   = 11'b001_0000_0000,
		S_WDIV = 11'b010_0000_0000,
		S_DONE = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [GAINS_W-1:0] prop_q;
	logic [GAINS_W-1:0] integ_gain_q;
	logic [GAINS_W-1:0] deriv_q;
	logic [WIN_W-1:0]   window_q;
	logic [SLOPE_W-1:0] slope_q;

	// Item registers.
	logic [JIDX_W-1:0]         joint_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [TICK_W-1:0]         ticks_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [PT_W-1:0]    pterm_q;
	logic signed [SUM_W-1:0]   sum_new_q;
	logic signed [TOT_W-1:0]   pi_q;
	logic signed [TOT_W-1:0]   tot_q;
	logic                      integ_q;
	logic                      vld_rd_q;
	logic [JOINT_COUNT-1:0]    vld_q;

	// Output register.
	logic                      out_valid_q;
	logic [TORQUE_W-1:0]       out_torque_q;
	logic                      out_sat_q;
	logic                      out_integ_q;

	// Shared multiplier.
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;

	// Memory and divider connections.
	logic                      ram_we;
	logic [RAM_AW-1:0]         ram_addr;
	logic [RAM_AW-1:0]         ram_raddr;
	logic [RAM_W-1:0]          ram_wdata;
	logic [RAM_W-1:0]          ram_rdata;
	logic signed [DIVD_W-1:0]  div_q;
	div_stat_t                 div_st;
	logic                      div_start;

	// Misc combinational values.
	logic                      in_acc;
	logic                      out_load;
	logic [JIDX_W-1:0]         in_joint;
	logic [TICK_W-1:0]         in_ticks;
	logic [GAIN_BITS-1:0]      kp_j;
	logic [GAIN_BITS-1:0]      ki_j;
	logic [GAIN_BITS-1:0]      kd_j;
	logic signed [DIFF_W-1:0]  err_ext;
	logic [DIFF_W-1:0]         mag;
	logic signed [DIFF_W:0]    diff_ext;
	logic [DIFF_W:0]           dmag;
	logic signed [ET_W:0]      sum_raw;
	logic signed [SUM_W-1:0]   sum_sat;
	logic                      sum_fits;
	logic                      tot_fits;
	logic [TORQUE_W-1:0]       tot_sat;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_joint      = s_axis_tuser[JIDX_W-1:0];
	assign in_ticks      = s_axis_tdata[ERR_W +: TICK_W];
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	// Gains of the joint at work.
	assign kp_j = gain_of(prop_q, joint_q);
	assign ki_j = gain_of(integ_gain_q, joint_q);
	assign kd_j = gain_of(deriv_q, joint_q);

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q       <= '0;
			integ_gain_q <= '0;
			deriv_q      <= '0;
			window_q     <= WINDOW_RESET;
			slope_q      <= SLOPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PROP:   prop_q       <= cfg_data;
				CFG_INTEG:  integ_gain_q <= cfg_data;
				CFG_DERIV:  deriv_q      <= cfg_data;
				CFG_WINDOW: window_q     <= cfg_data[WIN_W-1:0];
				CFG_SLOPE:  slope_q      <= cfg_data[SLOPE_W-1:0];
				default: ;
			endcase
		end
	end

	// Multiplier operands for each step of the sequence.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MP: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = MUL_B_W'(kp_j);
			end
			S_MD: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'(kd_j);
			end
			S_MS: begin
				mul_a = MUL_A_W'(slope_q);
				mul_b = MUL_B_W'(ticks_q);
			end
			S_ME: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = MUL_B_W'(ticks_q);
			end
			S_MI: begin
				mul_a = MUL_A_W'(sum_new_q);
				mul_b = MUL_B_W'(ki_j);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Magnitudes for the integration window and slope tests.
	always_comb begin
		err_ext  = DIFF_W'(err_q);
		mag      = err_ext[DIFF_W-1] ? DIFF_W'(-err_ext) : DIFF_W'(err_ext);
		diff_ext = (DIFF_W+1)'(diff_q);
		dmag     = diff_ext[DIFF_W] ? (DIFF_W+1)'(-diff_ext) : (DIFF_W+1)'(diff_ext);
	end

	// Integral update with saturation to the signed 32-bit range.
	always_comb begin
		sum_raw  = (ET_W+1)'(sum_q) + (ET_W+1)'($signed(prod_q[ET_W-1:0]));
		sum_fits = (&sum_raw[ET_W:SUM_W-1]) || !(|sum_raw[ET_W:SUM_W-1]);
		if (sum_fits) begin
			sum_sat = sum_raw[SUM_W-1:0];
		end else if (sum_raw[ET_W]) begin
			sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	// Torque saturation.
	always_comb begin
		tot_fits = (&tot_q[TOT_W-1:TORQUE_W-1]) || !(|tot_q[TOT_W-1:TORQUE_W-1]);
		if (tot_fits) begin
			tot_sat = tot_q[TORQUE_W-1:0];
		end else if (tot_q[TOT_W-1]) begin
			tot_sat = {1'b1, {(TORQUE_W-1){1'b0}}};
		end else begin
			tot_sat = {1'b0, {(TORQUE_W-1){1'b1}}};
		end
	end

	// State memory access: read on input transfer, write back after the integral update.
	assign ram_raddr = RAM_AW'(in_joint);
	assign ram_addr  = RAM_AW'(joint_q);
	assign ram_we    = (state_q == S_SUM);
	assign ram_wdata = {(integ_q ? sum_sat : SUM_W'(0)), err_q};
	assign div_start = (state_q == S_MS);

	mjpid_ram #(
		.WIDTH (RAM_W),
		.DEPTH (JOINT_COUNT)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mjpid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q[DIVD_W-1:0]),
		.divisor  (ticks_q),
		.quotient (div_q),
		.stat     (div_st)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= (in_joint < JOINT_COUNT) ? S_READ : S_DONE;
					end
				end
				S_READ: state_q <= S_MP;
				S_MP:   state_q <= S_MD;
				S_MD:   state_q <= S_MS;
				S_MS:   state_q <= S_ME;
				S_ME:   state_q <= S_SUM;
				S_SUM:  state_q <= S_MI;
				S_MI:   state_q <= S_WI;
				S_WI:   state_q <= S_WDIV;
				S_WDIV: begin
					if (div_st.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Per-joint valid bits: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[ram_addr] <= 1'b1;
		end
	end

	// Datapath registers along the sequence.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					joint_q  <= in_joint;
					err_q    <= s_axis_tdata[ERR_W-1:0];
					ticks_q  <= (in_ticks == '0) ? TICK_W'(1) : in_ticks;
					vld_rd_q <= vld_q[ram_raddr];
					tot_q    <= '0;
					integ_q  <= 1'b0;
				end
			end
			S_READ: begin
				if (vld_rd_q) begin
					sum_q  <= ram_rdata[ERR_W +: SUM_W];
					diff_q <= DIFF_W'(err_q) - DIFF_W'($signed(ram_rdata[ERR_W-1:0]));
				end else begin
					sum_q  <= '0;
					diff_q <= DIFF_W'(err_q);
				end
			end
			S_MD: pterm_q <= prod_q[PT_W-1:0];
			S_ME: begin
				integ_q <= (mag < DIFF_W'(window_q)) &&
				           (SUM_W'(dmag) < prod_q[SUM_W-1:0]);
			end
			S_SUM: sum_new_q <= integ_q ? sum_sat : SUM_W'(0);
			S_WI: pi_q <= TOT_W'(pterm_q) + TOT_W'($signed(prod_q[IT_W-1:0]));
			S_WDIV: begin
				if (div_st.done) begin
					tot_q <= pi_q + TOT_W'(div_q);
				end
			end
			default: ;
		endcase
	end

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_torque_q <= tot_sat;
			out_sat_q    <= !tot_fits;
			out_integ_q  <= integ_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_torque_q;
	assign m_axis_tuser  = {6'b0, out_integ_q, out_sat_q};

	// The state memory is written only for a joint that exists.
	a_we_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (joint_q < JOINT_COUNT))
		else $error("state write for a joint out of range");

	// A result is never formed while the divider still runs.
	a_div_idle_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !div_st.busy)
		else $error("result formed while divider busy");

	// After an input transfer no further item is taken in the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("second item taken while one is at work");

	// The divider starts only when it is free.
	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider started while busy");

endmodule

`default_nettype wire
